// ===== rtl/twlw_pkg.sv =====
package twlw_pkg;

  localparam int WINDOW_W = 4;
  localparam int CODE_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COLUMN_W = 5;
  localparam int GLYPH_W  = 9;
  localparam int COLOR_W  = 2;

  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;
  localparam logic [CODE_W-1:0] CODE_PERCENT = 8'd37;
  localparam logic [CODE_W-1:0] CODE_DIGIT0  = 8'd48;
  localparam logic [CODE_W-1:0] CODE_DIGIT3  = 8'd51;
  localparam logic [CODE_W-1:0] CODE_MAX     = 8'd126;

  localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 9'd32;

  typedef struct packed {
    logic [WINDOW_W-1:0] window;
    logic [CODE_W-1:0]   code;
    logic                last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [WINDOW_W-1:0] out_window;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
    logic [GLYPH_W-1:0]  glyph;
    logic                scroll_first;
    logic                last;
  } out_item_t;

endpackage

// ===== rtl/twlw_in_if.sv =====
interface twlw_in_if;
  logic               valid;
  logic               ready;
  twlw_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/twlw_out_if.sv =====
interface twlw_out_if;
  logic                valid;
  logic                ready;
  twlw_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/text_window_line_writer_core.sv =====
// Text window line writer.
// in_ch carries one formatted character per transaction (window, code,
// last_of_message); out_ch carries one transaction per column of an emitted
// line, column 0 first, last set on the final column.
// A printable character, a dropped code or a held percent keeps in_ch.ready low
// after acceptance through the state memory read, the held-percent check and the
// decode with line memory write and state write-back, so no new character is
// taken before it is done. A color digit after a held percent skips the decode.
// Tab and newline padding repeat the decode for each padded column past the first.
// A full line is read from the line memory one column at a time, each read
// followed by its hand-off into the output register before the next read.
// Characters for a window index at or above WINDOWS are accepted and dropped.
// The output register decouples the channels: the next character is taken
// while the last column still waits; a stalled out_ch holds further line reads.
// Synchronous reset clears the per-window color, row, fill count and held
// percent through per-entry valid bits; no clearing pass is needed and
// in_ch.ready is high in the first cycle after reset.
module text_window_line_writer_core #(
  parameter int WINDOWS      = 16,
  parameter int LINE_COLUMNS = 32,
  parameter int WINDOW_ROWS  = 24
) (
  input logic         clk,
  input logic         rst_n,
  twlw_in_if.sink     in_ch,
  twlw_out_if.source  out_ch
);

  localparam int WIN_W  = WINDOWS > 1 ? $clog2(WINDOWS) : 1;
  localparam int FILL_W = $clog2(LINE_COLUMNS + 1);
  localparam int COL_W  = $clog2(LINE_COLUMNS);
  localparam int ROWC_W = $clog2(WINDOW_ROWS + 1);
  localparam int LA_W   = $clog2(WINDOWS * LINE_COLUMNS);
  localparam int SD_W   = 1 + twlw_pkg::COLOR_W + ROWC_W + FILL_W;

  localparam logic [6:0]        WINDOWS_L = 7'(WINDOWS);
  localparam logic [FILL_W-1:0] COLS_F    = FILL_W'(LINE_COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(LINE_COLUMNS - 1);
  localparam logic [LA_W-1:0]   COLS_LA   = LA_W'(LINE_COLUMNS);
  localparam logic [ROWC_W-1:0] ROWS_R    = ROWC_W'(WINDOW_ROWS);
  localparam logic [ROWC_W-1:0] BOTTOM_R  = ROWC_W'(WINDOW_ROWS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_PCT   = 3'd2;
  localparam logic [2:0] ST_CODE  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [twlw_pkg::WINDOW_W-1:0] win_r, win_nxt;
  logic [twlw_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic                          lastm_r, lastm_nxt;
  logic [twlw_pkg::COLOR_W-1:0]  color_r, color_nxt;
  logic [ROWC_W-1:0]             row_r, row_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic                          pct_r, pct_nxt;
  logic                          after_r, after_nxt;
  logic                          scroll_r, scroll_nxt;
  logic [FILL_W-1:0]             fc_r, fc_nxt;
  logic                          rd_pend_r, rd_pend_nxt;
  logic [COL_W-1:0]              rcol_r, rcol_nxt;
  logic                          out_valid_r, out_valid_nxt;
  twlw_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                          win_ok;
  logic                          do_fin;
  logic                          is_tab, is_nl, is_sp, is_print, is_digit;
  logic                          put_now, more;
  logic [FILL_W-1:0]             fill_a;
  logic [LA_W-1:0]               win_la, line_base;

  logic                          sm_re, sm_we;
  logic [WIN_W-1:0]              sm_raddr, sm_waddr;
  logic [SD_W-1:0]               sm_rdata, sm_wdata;
  logic                          lm_re, lm_we;
  logic [LA_W-1:0]               lm_raddr, lm_waddr;
  logic [twlw_pkg::GLYPH_W-1:0]  lm_rdata, lm_wdata;

  twlw_state_mem #(
    .DEPTH  (WINDOWS),
    .DATA_W (SD_W)
  ) u_state_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata)
  );

  twlw_line_mem #(
    .DEPTH  (WINDOWS * LINE_COLUMNS),
    .DATA_W (twlw_pkg::GLYPH_W)
  ) u_line_mem (
    .clk   (clk),
    .re    (lm_re),
    .raddr (lm_raddr),
    .rdata (lm_rdata),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata)
  );

  assign win_ok    = 7'(in_ch.data.window) < WINDOWS_L;
  assign sm_raddr  = WIN_W'(in_ch.data.window);
  assign sm_waddr  = WIN_W'(win_r);
  assign sm_wdata  = {pct_nxt, color_nxt, row_nxt, fill_nxt};
  assign sm_we     = do_fin;
  assign win_la    = LA_W'(WIN_W'(win_r));
  assign line_base = win_la * COLS_LA;

  assign is_tab   = code_r == twlw_pkg::CODE_TAB;
  assign is_nl    = code_r == twlw_pkg::CODE_NEWLINE;
  assign is_sp    = code_r == twlw_pkg::CODE_SPACE;
  assign is_print = (code_r > twlw_pkg::CODE_SPACE) && (code_r <= twlw_pkg::CODE_MAX);
  assign is_digit = (code_r >= twlw_pkg::CODE_DIGIT0) && (code_r <= twlw_pkg::CODE_DIGIT3);

  assign in_ch.ready  = st_r == ST_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    st_nxt        = st_r;
    win_nxt       = win_r;
    code_nxt      = code_r;
    lastm_nxt     = lastm_r;
    color_nxt     = color_r;
    row_nxt       = row_r;
    fill_nxt      = fill_r;
    pct_nxt       = pct_r;
    after_nxt     = after_r;
    scroll_nxt    = scroll_r;
    fc_nxt        = fc_r;
    rd_pend_nxt   = rd_pend_r;
    rcol_nxt      = rcol_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    do_fin        = 1'b0;
    sm_re         = 1'b0;
    lm_re         = 1'b0;
    lm_we         = 1'b0;
    lm_raddr      = line_base + LA_W'(fc_r);
    lm_waddr      = line_base + LA_W'(fill_r);
    lm_wdata      = twlw_pkg::GLYPH_BLANK;
    put_now       = 1'b0;
    more          = 1'b0;
    fill_a        = fill_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid && win_ok) begin
          win_nxt   = in_ch.data.window;
          code_nxt  = in_ch.data.code;
          lastm_nxt = in_ch.data.last_of_message;
          sm_re     = 1'b1;
          st_nxt    = ST_LOAD;
        end
      end

      ST_LOAD: begin
        {pct_nxt, color_nxt, row_nxt, fill_nxt} = sm_rdata;
        st_nxt = ST_PCT;
      end

      ST_PCT: begin
        if (!pct_r) begin
          st_nxt = ST_CODE;
        end else begin
          pct_nxt = 1'b0;
          if (is_digit) begin
            color_nxt = code_r[twlw_pkg::COLOR_W-1:0];
            do_fin    = 1'b1;
          end else begin
            // release the held percent as a literal
            lm_we    = 1'b1;
            lm_wdata = {color_r, twlw_pkg::CODE_PERCENT[6:0]};
            fill_a   = fill_r + FILL_W'(1);
            fill_nxt = fill_a;
            if (fill_a == COLS_F) begin
              scroll_nxt = row_r >= ROWS_R;
              row_nxt    = (row_r >= ROWS_R) ? BOTTOM_R : row_r;
              fc_nxt     = '0;
              after_nxt  = 1'b1;
              st_nxt     = ST_FLUSH;
            end else begin
              st_nxt = ST_CODE;
            end
          end
        end
      end

      ST_CODE: begin
        if (code_r == twlw_pkg::CODE_PERCENT && !lastm_r) begin
          pct_nxt = 1'b1;
          do_fin  = 1'b1;
        end else begin
          if (fill_r < COLS_F) begin
            if (is_tab) begin
              put_now = fill_r[1:0] != 2'd0;
            end else begin
              put_now = is_nl || is_sp || is_print;
            end
          end
          fill_a = fill_r + FILL_W'(put_now);
          if (is_tab) begin
            more = put_now && (fill_a[1:0] != 2'd0) && (fill_a < COLS_F);
          end else if (is_nl) begin
            more = fill_a < COLS_F;
          end
          lm_we    = put_now;
          lm_wdata = is_print ? {color_r, code_r[6:0]} : twlw_pkg::GLYPH_BLANK;
          fill_nxt = fill_a;
          if (!more) begin
            if (fill_a == COLS_F) begin
              scroll_nxt = row_r >= ROWS_R;
              row_nxt    = (row_r >= ROWS_R) ? BOTTOM_R : row_r;
              fc_nxt     = '0;
              after_nxt  = 1'b0;
              st_nxt     = ST_FLUSH;
            end else begin
              do_fin = 1'b1;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (rd_pend_r) begin
          rd_pend_nxt                = 1'b0;
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_window    = win_r;
          out_data_nxt.row           = twlw_pkg::ROW_W'(row_r);
          out_data_nxt.column        = twlw_pkg::COLUMN_W'(rcol_r);
          out_data_nxt.glyph         = lm_rdata;
          out_data_nxt.scroll_first  = scroll_r && (rcol_r == '0);
          out_data_nxt.last          = rcol_r == LAST_COL;
          if (rcol_r == LAST_COL) begin
            row_nxt  = ROWC_W'(row_r + ROWC_W'(1));
            fill_nxt = '0;
            if (after_r) begin
              st_nxt = ST_CODE;
            end else begin
              do_fin = 1'b1;
            end
          end
        end else if (fc_r < COLS_F && (!out_valid_r || out_ch.ready)) begin
          lm_re       = 1'b1;
          rd_pend_nxt = 1'b1;
          rcol_nxt    = COL_W'(fc_r);
          fc_nxt      = fc_r + FILL_W'(1);
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (do_fin) begin
      st_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    code_r     <= code_nxt;
    lastm_r    <= lastm_nxt;
    color_r    <= color_nxt;
    row_r      <= row_nxt;
    fill_r     <= fill_nxt;
    pct_r      <= pct_nxt;
    after_r    <= after_nxt;
    scroll_r   <= scroll_nxt;
    fc_r       <= fc_nxt;
    rcol_r     <= rcol_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/twlw_state_mem.sv =====
module twlw_state_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                    rdata,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                    wdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] q_r;
  logic              qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        qv_r <= vld_r[raddr];
      end
    end
  end

  // entries never written read as the reset state
  assign rdata = qv_r ? q_r : '0;

endmodule

// ===== rtl/twlw_line_mem.sv =====
module twlw_line_mem #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 9
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_r;

endmodule
